// ----- rtl/core/fevd_pkg.sv -----
// Shared types, constants and command structs for the frame energy voice detector.
package fevd_pkg;

   localparam int MaxFrames   = 64;
   localparam int MaxChannels = 8;
   localparam int FrameIdxW   = $clog2(MaxFrames + 1);
   localparam int StoreIdxW   = (MaxFrames > 1) ? $clog2(MaxFrames) : 1;

   localparam logic [1:0] CSR_FRAME_LENGTH   = 2'd0;
   localparam logic [1:0] CSR_CHANNEL_COUNT  = 2'd1;
   localparam logic [1:0] CSR_BASE_THRESHOLD = 2'd2;

   localparam logic [18:0] TotalMax    = 19'h7FFFF;
   localparam logic [13:0] ThreshScale = 14'd11796;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SQRT,
      ST_STORE,
      ST_THRESH,
      ST_READ,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;      // Accumulate the sample held at the input.
      logic div_start;   // Load the divider with sum and count.
      logic div_step;
      logic sqrt_start;
      logic sqrt_step;
      logic store;       // Close the frame: write energy, update max.
      logic thresh;      // Compute effective threshold.
      logic rd_start;    // Reset read pointer.
      logic rd_issue;    // Issue a store read.
      logic emit_load;   // Load the output register.
      logic clear;       // Return run state to reset.
   } cmd_type;

   typedef struct packed {
      logic close_pending; // The last accepted sample closes a frame.
      logic last_pending;  // The last accepted sample was marked last.
      logic div_done;
      logic sqrt_done;
      logic rd_more;       // More stored frames remain to be read.
      logic out_busy;      // Output register holds an untaken beat.
      logic out_last;      // Beat in output register is the final one.
   } status_type;

endpackage

// ----- rtl/core/frame_energy_voice_detector.sv -----
// Top level of the frame energy voice detector.
//  channel | dir | beat payload
//  req_    | in  | tdata: sample[15:0]; tlast: is_last
//  rsp_    | out | tdata: frame_start, frame_end, energy, speech, overflow; tlast: last_frame
//  csr_    | in  | we, index[1:0], wdata[15:0]
// Ordinary samples are taken back to back, with no gap between them.
// A sample that closes a frame holds req_ off while the divider is loaded and runs 46 steps,
// the square root is loaded and runs 23 steps, and the energy is stored. On a last sample
// the threshold is then set, and each stored frame is read once the output register is free
// and then loaded into it; req_ stays off until the final beat is loaded.
// Reset is synchronous and clears all run state; the energy store is not cleared.
module frame_energy_voice_detector (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // sample
   input  logic        req_tlast,  // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // frame_start, frame_end, energy, speech, overflow
   output logic        rsp_tlast,  // last_frame
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import fevd_pkg::*;

   cmd_type    cmd;
   status_type sts;
   logic [17:0] f_start;
   logic [18:0] f_end;
   logic [15:0] f_energy;
   logic        f_speech;
   logic        f_overflow;

   fevd_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .sts(sts), .cmd(cmd)
   );

   fevd_datapath u_dp (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .in_sample(req_tdata), .in_is_last(req_tlast),
      .cmd(cmd), .sts(sts), .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_frame_start(f_start), .out_frame_end(f_end), .out_energy(f_energy),
      .out_speech(f_speech), .out_overflow(f_overflow), .out_last_frame(rsp_tlast)
   );

   assign rsp_tdata = {1'b0, f_overflow, f_speech, f_energy, f_end, f_start};

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step || cmd.sqrt_step) |-> !req_tready)
      else $error("input taken during frame close");
   a_one_phase: assert property (@(posedge clock) disable iff (reset)
      !(cmd.accept && cmd.emit_load))
      else $error("accept and emit overlap");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat dropped");
endmodule

// ----- rtl/core/fevd_datapath.sv -----
// Datapath: accumulation, iterative divide and square root, energy store and result register.
module fevd_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_wdata,
   input  logic signed [15:0]   in_sample,
   input  logic                 in_is_last,
   input  fevd_pkg::cmd_type    cmd,
   output fevd_pkg::status_type sts,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [17:0]          out_frame_start,
   output logic [18:0]          out_frame_end,
   output logic [15:0]          out_energy,
   output logic                 out_speech,
   output logic                 out_overflow,
   output logic                 out_last_frame
);
   import fevd_pkg::*;

   logic [12:0] frame_length_ff;
   logic [3:0]  channel_count_ff;
   logic [15:0] base_threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff   <= 13'd480;
         channel_count_ff  <= 4'd1;
         base_threshold_ff <= 16'd655;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_LENGTH:   frame_length_ff   <= csr_wdata[12:0];
            CSR_CHANNEL_COUNT:  channel_count_ff  <= csr_wdata[3:0];
            CSR_BASE_THRESHOLD: base_threshold_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [12:0] fl;
   logic [3:0]  ch;
   always_comb begin
      fl = frame_length_ff;
      if (fl == 13'd0) fl = 13'd1;
      else if (fl > 13'd4096) fl = 13'd4096;
      ch = channel_count_ff;
      if (ch == 4'd0) ch = 4'd1;
      else if (ch > 4'(MaxChannels)) ch = 4'(MaxChannels);
   end

   // Run state.
   logic [45:0] sum_ff, sum_in;
   logic [12:0] group_ff, group_in;
   logic [2:0]  chan_ff, chan_in;
   logic [3:0]  chan_next;
   logic [15:0] count_ff, count_in;
   logic [18:0] total_ff, total_in;
   logic [15:0] max_ff;
   logic [FrameIdxW-1:0] fidx_ff;
   logic        drop_ff;
   logic        close_ff, close_in;
   logic        last_ff;
   logic signed [31:0] samp_ext;
   logic [31:0] sq;

   assign samp_ext = {{16{in_sample[15]}}, in_sample};
   assign sq       = samp_ext * samp_ext;

   always_comb begin
      sum_in    = sum_ff + {14'd0, sq};
      count_in  = count_ff + 16'd1;
      chan_next = {1'b0, chan_ff} + 4'd1;
      chan_in   = chan_next[2:0];
      group_in  = group_ff;
      total_in  = total_ff;
      close_in  = 1'b0;
      if (chan_next >= ch || in_is_last) begin
         chan_in  = 3'd0;
         group_in = group_ff + 13'd1;
         if (total_ff < TotalMax) total_in = total_ff + 19'd1;
         close_in = (group_in >= fl) || in_is_last;
      end
   end

   // Restoring divider: 46-bit sum by 16-bit count.
   logic [45:0] quot_ff;
   logic [15:0] rem_ff;
   logic [5:0]  div_cnt_ff;
   logic [16:0] rem_sh;
   logic [16:0] rem_sub;
   assign rem_sh  = {rem_ff, quot_ff[45]};
   assign rem_sub = rem_sh - {1'b0, count_ff};

   // Square root: 46-bit radicand, 23 result bits.
   logic [45:0] rad_ff;
   logic [23:0] root_ff;
   logic [23:0] srem_ff;
   logic [4:0]  sqrt_cnt_ff;
   logic [25:0] srem_sh;
   logic [25:0] strial;
   logic [25:0] srem_sub;
   assign srem_sh  = {srem_ff, rad_ff[45:44]};
   assign strial   = {root_ff, 2'b01};
   assign srem_sub = srem_sh - strial;

   logic [15:0] energy;
   assign energy = root_ff[15:0];

   // Energy store.
   logic [15:0] store_mem [MaxFrames];
   logic [15:0] rd_data_ff;
   logic [StoreIdxW-1:0] rd_ptr_ff;
   logic [FrameIdxW-1:0] rd_k_ff;
   logic [17:0] start_ff;
   logic [15:0] thr_ff;
   logic [29:0] prod;
   logic [15:0] scaled_max;
   assign prod       = max_ff * ThreshScale;
   assign scaled_max = {2'b00, prod[29:16]};

   always_ff @(posedge clock) begin
      if (cmd.store && fidx_ff < FrameIdxW'(MaxFrames))
         store_mem[fidx_ff[StoreIdxW-1:0]] <= energy;
      if (cmd.rd_issue)
         rd_data_ff <= store_mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         sum_ff   <= '0;
         group_ff <= '0;
         chan_ff  <= '0;
         count_ff <= '0;
         total_ff <= '0;
         max_ff   <= '0;
         fidx_ff  <= '0;
         drop_ff  <= 1'b0;
         close_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         if (cmd.accept) begin
            sum_ff   <= sum_in;
            count_ff <= count_in;
            chan_ff  <= chan_in;
            group_ff <= group_in;
            total_ff <= total_in;
            close_ff <= close_in;
            last_ff  <= in_is_last;
         end
         if (cmd.store) begin
            if (energy > max_ff) max_ff <= energy;
            if (fidx_ff < FrameIdxW'(MaxFrames)) fidx_ff <= fidx_ff + 1'b1;
            else drop_ff <= 1'b1;
            sum_ff   <= '0;
            count_ff <= '0;
            group_ff <= '0;
            close_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         quot_ff    <= sum_ff;
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         if (rem_sh >= {1'b0, count_ff}) begin
            rem_ff  <= rem_sub[15:0];
            quot_ff <= {quot_ff[44:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh[15:0];
            quot_ff <= {quot_ff[44:0], 1'b0};
         end
         div_cnt_ff <= div_cnt_ff + 6'd1;
      end
      if (cmd.sqrt_start) begin
         rad_ff      <= (count_ff == 16'd0) ? 46'd0 : quot_ff;
         root_ff     <= '0;
         srem_ff     <= '0;
         sqrt_cnt_ff <= '0;
      end else if (cmd.sqrt_step) begin
         rad_ff <= {rad_ff[43:0], 2'b00};
         if (srem_sh >= strial) begin
            srem_ff <= srem_sub[23:0];
            root_ff <= {root_ff[22:0], 1'b1};
         end else begin
            srem_ff <= srem_sh[23:0];
            root_ff <= {root_ff[22:0], 1'b0};
         end
         sqrt_cnt_ff <= sqrt_cnt_ff + 5'd1;
      end
      if (cmd.thresh)
         thr_ff <= (base_threshold_ff > scaled_max) ? base_threshold_ff : scaled_max;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         rd_k_ff   <= '0;
      end else if (cmd.rd_start) begin
         rd_ptr_ff <= '0;
         rd_k_ff   <= '0;
         start_ff  <= '0;
      end else if (cmd.rd_issue) begin
         rd_ptr_ff <= rd_ptr_ff + 1'b1;
         rd_k_ff   <= rd_k_ff + 1'b1;
      end else if (cmd.emit_load) begin
         start_ff <= start_ff + {5'd0, fl};
      end
   end

   logic [19:0] end_sum;
   assign end_sum = {2'd0, start_ff} + {7'd0, fl};

   logic valid_ff;
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (cmd.emit_load) valid_ff <= 1'b1;
      else if (out_ready) valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         out_frame_start <= start_ff;
         out_frame_end   <= (end_sum > {1'b0, total_ff}) ? total_ff : end_sum[18:0];
         out_energy      <= rd_data_ff;
         out_speech      <= rd_data_ff >= thr_ff;
         out_overflow    <= drop_ff;
         out_last_frame  <= rd_k_ff == fidx_ff;
      end
   end

   assign out_valid = valid_ff;

   always_comb begin
      sts.close_pending = close_ff;
      sts.last_pending  = last_ff;
      sts.div_done      = div_cnt_ff == 6'd46;
      sts.sqrt_done     = sqrt_cnt_ff == 5'd22;
      sts.rd_more       = rd_k_ff < fidx_ff;
      sts.out_busy      = valid_ff && !out_ready;
      sts.out_last      = out_last_frame;
   end
endmodule

// ----- rtl/core/fevd_ctrl.sv -----
// Controller state machine sequencing accumulation, frame close and result output.
module fevd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  fevd_pkg::status_type sts,
   output fevd_pkg::cmd_type    cmd
);
   import fevd_pkg::*;

   state_type state_ff, state_in;
   logic      pend_ff, pend_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      pend_in  = 1'b0;
      cmd      = '0;
      in_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (pend_ff && sts.close_pending) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               in_ready   = 1'b1;
               cmd.accept = in_valid;
               pend_in    = in_valid;
            end
         end
         ST_DIV: begin
            if (sts.div_done) begin
               cmd.sqrt_start = 1'b1;
               state_in       = ST_SQRT;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (sts.sqrt_done) state_in = ST_STORE;
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            state_in  = sts.last_pending ? ST_THRESH : ST_IDLE;
         end
         ST_THRESH: begin
            cmd.thresh   = 1'b1;
            cmd.rd_start = 1'b1;
            state_in     = ST_READ;
         end
         ST_READ: begin
            if (!sts.out_busy) begin
               cmd.rd_issue = 1'b1;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.emit_load = 1'b1;
            state_in      = sts.rd_more ? ST_READ : ST_IDLE;
            cmd.clear     = !sts.rd_more;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

// ----- tb/fevd_checker.sv -----
// Result checker for the frame energy voice detector: predicts frame results and compares beats.
`timescale 1ns / 1ps
module fevd_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending_count
);
   import fevd_pkg::*;

   typedef struct packed {
      logic [17:0] frame_start;
      logic [18:0] frame_end;
      logic [15:0] energy;
      logic        speech;
      logic        overflow;
      logic        last_frame;
   } frame_result_t;

   frame_result_t frame_results[$];

   logic [12:0] cfg_frame_length;
   logic [3:0]  cfg_channels;
   logic [15:0] cfg_threshold;

   logic [63:0] sq_sum;
   int unsigned grp_count, chan_idx, smp_count, n_stored, tot_groups, peak_energy;
   logic        dropped;
   int unsigned energies[MaxFrames];

   function automatic int unsigned int_sqrt(logic [63:0] v);
      logic [63:0] res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w >>= 2;
      while (bit_w != 0) begin
         if (v >= res + bit_w) begin
            v = v - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res >>= 1;
         end
         bit_w >>= 2;
      end
      return res[31:0];
   endfunction

   task automatic close_frame();
      int unsigned e;
      e = 0;
      if (smp_count != 0) e = int_sqrt(sq_sum / smp_count);
      if (e > peak_energy) peak_energy = e;
      if (n_stored < MaxFrames) begin
         energies[n_stored] = e;
         n_stored++;
      end else begin
         dropped = 1'b1;
      end
      sq_sum = 0;
      smp_count = 0;
      grp_count = 0;
   endtask

   task automatic clear_run();
      sq_sum = 0;
      grp_count = 0;
      chan_idx = 0;
      smp_count = 0;
      n_stored = 0;
      tot_groups = 0;
      peak_energy = 0;
      dropped = 1'b0;
   endtask

   task automatic accumulate_sample(logic signed [15:0] s, logic is_last);
      int unsigned fl, ch, thr, start, stop;
      logic signed [31:0] sq;
      frame_result_t r;
      fl = (cfg_frame_length == 0) ? 1 : (cfg_frame_length > 4096) ? 4096 : cfg_frame_length;
      ch = (cfg_channels == 0) ? 1 : (cfg_channels > MaxChannels) ? MaxChannels : cfg_channels;
      sq = s * s;
      sq_sum += 64'(unsigned'(sq));
      smp_count++;
      chan_idx++;
      if (chan_idx >= ch || is_last) begin
         chan_idx = 0;
         grp_count++;
         if (tot_groups < TotalMax) tot_groups++;
         if (grp_count >= fl && !is_last) close_frame();
      end
      if (is_last) begin
         close_frame();
         thr = (peak_energy * 11796) >> 16;
         if (cfg_threshold > thr) thr = cfg_threshold;
         for (int k = 0; k < n_stored; k++) begin
            start = k * fl;
            stop = start + fl;
            if (stop > tot_groups) stop = tot_groups;
            r.frame_start = start[17:0];
            r.frame_end = stop[18:0];
            r.energy = energies[k][15:0];
            r.speech = energies[k] >= thr;
            r.overflow = dropped;
            r.last_frame = (k + 1 == n_stored);
            frame_results = {frame_results, r};
         end
         clear_run();
      end
   endtask

   always @(posedge clock) begin
      frame_result_t want, got;
      if (reset) begin
         cfg_frame_length <= 13'd480;
         cfg_channels <= 4'd1;
         cfg_threshold <= 16'd655;
         clear_run();
         frame_results.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FRAME_LENGTH:   cfg_frame_length <= csr_wdata[12:0];
               CSR_CHANNEL_COUNT:  cfg_channels <= csr_wdata[3:0];
               CSR_BASE_THRESHOLD: cfg_threshold <= csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) accumulate_sample(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[17:0], rsp_tdata[36:18], rsp_tdata[52:37], rsp_tdata[53],
                   rsp_tdata[54], rsp_tlast};
            if (frame_results.size() == 0) begin
               $display("%0t: unexpected result beat %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = frame_results.pop_front();
               if (want !== got) begin
                  $display("%0t: expected start=%0d end=%0d energy=%0d sp=%0d ovf=%0d last=%0d",
                           $time, want.frame_start, want.frame_end, want.energy, want.speech,
                           want.overflow, want.last_frame);
                  $display("%0t: actual   start=%0d end=%0d energy=%0d sp=%0d ovf=%0d last=%0d",
                           $time, got.frame_start, got.frame_end, got.energy, got.speech,
                           got.overflow, got.last_frame);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= frame_results.size();
      end
   end
endmodule

// ----- tb/tb_frame_energy_voice_detector.sv -----
// Testbench top for the frame energy voice detector: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb_frame_energy_voice_detector;
   import fevd_pkg::*;

   logic        clock, reset;
   logic        req_tvalid, req_tready, req_tlast;
   logic [15:0] req_tdata;
   logic        rsp_tvalid, rsp_tready, rsp_tlast;
   logic [55:0] rsp_tdata;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;
   int          fail_count, pending_count;
   int          idle_pct, hold_cycles;

   frame_energy_voice_detector dut (.*);
   fevd_checker checker_i (.*);

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   initial begin
      #50_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Receiver: random stalls, plus one long hold-off when requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= idle_pct);
      end
   end

   task automatic send_beat(logic [15:0] s, logic is_last);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= s;
      req_tlast <= is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(200)) - 16'd100;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic run_recording(int n);
      for (int i = 0; i < n; i++) send_beat(rand_sample(), i == n - 1);
   endtask

   initial begin
      int n;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_FRAME_LENGTH;
      csr_wdata = '0;
      idle_pct = 27;
      hold_cycles = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: a single full-scale sample at reset settings.
      send_beat(16'h8000, 1'b1);
      drain();
      write_reg(CSR_FRAME_LENGTH, 16'd0);
      write_reg(CSR_CHANNEL_COUNT, 16'd0);
      write_reg(CSR_BASE_THRESHOLD, 16'd32768);
      send_beat(16'h7FFF, 1'b0);
      send_beat(16'h0000, 1'b0);
      send_beat(16'hFFFF, 1'b1);
      drain();
      // Channel count above the maximum, partial group at the end.
      write_reg(CSR_FRAME_LENGTH, 16'd2);
      write_reg(CSR_CHANNEL_COUNT, 16'd15);
      write_reg(CSR_BASE_THRESHOLD, 16'd0);
      for (int i = 0; i < 19; i++) send_beat(i[0] ? 16'h8000 : 16'h0001, i == 18);
      drain();
      // Frame length above the limit and the register's all-ones value.
      write_reg(CSR_FRAME_LENGTH, 16'h1FFF);
      write_reg(CSR_CHANNEL_COUNT, 16'd8);
      run_recording(6);
      drain();

      // Store overflow with a long receiver hold-off while the next samples wait for req_.
      write_reg(CSR_FRAME_LENGTH, 16'd1);
      write_reg(CSR_CHANNEL_COUNT, 16'd1);
      write_reg(CSR_BASE_THRESHOLD, 16'd655);
      run_recording(70);
      hold_cycles = 600;
      run_recording(5);
      drain();

      // Random recordings under varied settings; mid-run register write once.
      for (int r = 0; r < 12; r++) begin
         idle_pct = (r == 5) ? 0 : 27;
         write_reg(CSR_FRAME_LENGTH, 16'($urandom_range(1, 6)));
         write_reg(CSR_CHANNEL_COUNT, 16'($urandom_range(1, 8)));
         write_reg(CSR_BASE_THRESHOLD,
                   ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2000)));
         n = $urandom_range(5, 30);
         if (r == 3) begin
            run_recording(n);
            drain();
         end else begin
            for (int i = 0; i < n; i++) begin
               if (r == 7 && i == n / 2) begin
                  // Frame length changed mid recording, once the block is idle.
                  req_tvalid <= 1'b0;
                  @(posedge clock);
                  while (!req_tready) @(posedge clock);
                  write_reg(CSR_FRAME_LENGTH, 16'd3);
               end
               send_beat(rand_sample(), i == n - 1);
            end
            drain();
         end
      end

      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
